// ----- src/tgad_pkg.sv -----
// shared types and constants for the tga true-color rle pixel decoder
// no dependencies; used by the decoder top level and the testbench
`default_nettype none

package tgad_pkg;

  // parser phase
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HEADER = 3'd1,
    PH_IDSKIP = 3'd2,
    PH_PACKET = 3'd3,
    PH_PIXELS = 3'd4,
    PH_DONE   = 3'd5
  } phase_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_COLOR_MAP = 3'd1,
    ST_ZERO_SIZE = 3'd2,
    ST_BAD_DEPTH = 3'd3,
    ST_BAD_TYPE  = 3'd4,
    ST_TRUNCATED = 3'd5
  } status_t;

  // header byte positions
  localparam logic [4:0] HB_IDLEN    = 5'd0;
  localparam logic [4:0] HB_CMAP     = 5'd1;
  localparam logic [4:0] HB_TYPE     = 5'd2;
  localparam logic [4:0] HB_WIDTH_LO = 5'd12;
  localparam logic [4:0] HB_WIDTH_HI = 5'd13;
  localparam logic [4:0] HB_HEIGHT_LO = 5'd14;
  localparam logic [4:0] HB_HEIGHT_HI = 5'd15;
  localparam logic [4:0] HB_DEPTH    = 5'd16;
  localparam logic [4:0] HB_DESC     = 5'd17;

  // image type and depth codes
  localparam logic [7:0] TYPE_RAW  = 8'd2;
  localparam logic [7:0] TYPE_RLE  = 8'd10;
  localparam logic [7:0] DEPTH_24  = 8'd24;
  localparam logic [7:0] DEPTH_32  = 8'd32;

  // descriptor bit for row order, packet header fields
  localparam int unsigned DESC_TOP_BIT  = 5;
  localparam logic [7:0]  PKT_COUNT_MASK = 8'h7F;
  localparam int unsigned PKT_REPEAT_BIT = 7;
  localparam logic [7:0]  ALPHA_OPAQUE  = 8'd255;
  localparam int unsigned RUN_MAX       = 128;

  // parsed header
  typedef struct packed {
    logic [7:0]  idlen;
    logic        cmap;
    logic        top;
    logic [7:0]  img_type;
    logic [15:0] width;
    logic [15:0] height;
    logic [7:0]  depth;
  } hdr_t;

  // one result beat
  typedef struct packed {
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [7:0]  alpha;
    logic [31:0] first_index;
    logic [7:0]  run_length;
    logic        top_down;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        image_done;
    status_t     status;
  } result_t;

endpackage

`default_nettype wire

// ----- src/tgad_if.sv -----
// valid/ready channel interfaces for the tga decoder: byte input and run output
// depends on nothing; field widths follow the decoder's item layout
`default_nettype none

interface tgad_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       file_start;
  logic       file_end;

  modport source (output valid, data_byte, file_start, file_end, input ready);
  modport sink   (input valid, data_byte, file_start, file_end, output ready);
endinterface

interface tgad_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  blue;
  logic [7:0]  green;
  logic [7:0]  red;
  logic [7:0]  alpha;
  logic [31:0] first_index;
  logic [7:0]  run_length;
  logic        top_down;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic        image_done;
  logic [2:0]  status;

  modport source (output valid, blue, green, red, alpha, first_index, run_length,
                  top_down, image_width, image_height, image_done, status,
                  input ready);
  modport sink   (input valid, blue, green, red, alpha, first_index, run_length,
                  top_down, image_width, image_height, image_done, status,
                  output ready);
endinterface

`default_nettype wire

// ----- src/tga_rle_pixel_decoder.sv -----
// a result is written to the output register when the byte that causes it is accepted
// throughput: one file byte per cycle; the input is stalled only while a result waits
// unread and the output register cannot be freed in the same cycle
// the parser state updates directly from each accepted byte; the 16x16 product for the
// pixel count is registered at the last header byte
// reset (rst, synchronous): parser idle until a byte with file_start, output empty
`default_nettype none

module tga_rle_pixel_decoder (
  input  wire         clk,
  input  wire         rst,
  tgad_in_if.sink     byte_in,
  tgad_out_if.source  pix_out
);

  // parser state
  tgad_pkg::phase_t  phase, phase_next;
  logic [4:0]        hcount, hcount_next;
  tgad_pkg::hdr_t    hdr, hdr_next;
  logic [7:0]        idskip, idskip_next;
  logic [31:0]       pixels_done, pixels_done_next;
  logic [31:0]       total, total_next;
  logic [7:0]        pkt_left, pkt_left_next;
  logic              pkt_repeat, pkt_repeat_next;
  logic [1:0]        pbcount, pbcount_next;
  logic [23:0]       pbytes, pbytes_next;

  // output register
  logic                 out_valid;
  tgad_pkg::result_t    out_reg;

  // view of the state after a file start
  tgad_pkg::phase_t  c_phase;
  logic [4:0]        c_hcount;
  tgad_pkg::hdr_t    c_hdr;
  logic [7:0]        c_idskip;
  logic [31:0]       c_done;
  logic [31:0]       c_total;
  logic [7:0]        c_pkt_left;
  logic              c_pkt_repeat;
  logic [1:0]        c_pbcount;
  logic [23:0]       c_pbytes;

  logic              in_fire;
  logic [7:0]        b;
  logic              res_valid;
  logic              no_trunc;
  tgad_pkg::result_t res;
  logic [7:0]        px_b, px_g, px_r, px_a;
  logic [31:0]       left;
  logic [7:0]        run;
  logic              is_rle;
  logic              last_byte;
  tgad_pkg::status_t hdr_status;

  assign in_fire      = byte_in.valid && byte_in.ready;
  assign byte_in.ready = !out_valid || pix_out.ready;
  assign b            = byte_in.data_byte;

  // restart view: a file start clears everything and begins the header
  always_comb begin
    if (byte_in.file_start) begin
      c_phase      = tgad_pkg::PH_HEADER;
      c_hcount     = '0;
      c_hdr        = '0;
      c_idskip     = '0;
      c_done       = '0;
      c_total      = '0;
      c_pkt_left   = '0;
      c_pkt_repeat = 1'b0;
      c_pbcount    = '0;
      c_pbytes     = '0;
    end else begin
      c_phase      = phase;
      c_hcount     = hcount;
      c_hdr        = hdr;
      c_idskip     = idskip;
      c_done       = pixels_done;
      c_total      = total;
      c_pkt_left   = pkt_left;
      c_pkt_repeat = pkt_repeat;
      c_pbcount    = pbcount;
      c_pbytes     = pbytes;
    end
  end

  // byte processing
  always_comb begin
    phase_next       = c_phase;
    hcount_next      = c_hcount;
    hdr_next         = c_hdr;
    idskip_next      = c_idskip;
    pixels_done_next = c_done;
    total_next       = c_total;
    pkt_left_next    = c_pkt_left;
    pkt_repeat_next  = c_pkt_repeat;
    pbcount_next     = c_pbcount;
    pbytes_next      = c_pbytes;
    res_valid        = 1'b0;
    no_trunc         = 1'b0;
    hdr_status       = tgad_pkg::ST_OK;
    is_rle           = (c_hdr.img_type == tgad_pkg::TYPE_RLE);
    last_byte        = (c_pbcount == ((c_hdr.depth == tgad_pkg::DEPTH_32) ? 2'd3 : 2'd2));
    left             = c_total - c_done;
    run              = 8'd1;
    px_b             = '0;
    px_g             = '0;
    px_r             = '0;
    px_a             = '0;
    res              = '0;

    case (c_phase)
      tgad_pkg::PH_HEADER: begin
        // capture header fields by byte position
        case (c_hcount)
          tgad_pkg::HB_IDLEN:     hdr_next.idlen         = b;
          tgad_pkg::HB_CMAP:      hdr_next.cmap          = (b != 8'd0);
          tgad_pkg::HB_TYPE:      hdr_next.img_type      = b;
          tgad_pkg::HB_WIDTH_LO:  hdr_next.width[7:0]    = b;
          tgad_pkg::HB_WIDTH_HI:  hdr_next.width[15:8]   = b;
          tgad_pkg::HB_HEIGHT_LO: hdr_next.height[7:0]   = b;
          tgad_pkg::HB_HEIGHT_HI: hdr_next.height[15:8]  = b;
          tgad_pkg::HB_DEPTH:     hdr_next.depth         = b;
          tgad_pkg::HB_DESC:      hdr_next.top           = b[tgad_pkg::DESC_TOP_BIT];
          default:                hdr_next.idlen         = c_hdr.idlen;
        endcase
        hcount_next = c_hcount + 5'd1;
        if (c_hcount == tgad_pkg::HB_DESC) begin
          // header checks in priority order
          if (hdr_next.cmap) begin
            hdr_status = tgad_pkg::ST_COLOR_MAP;
          end else if (hdr_next.width == 16'd0 || hdr_next.height == 16'd0) begin
            hdr_status = tgad_pkg::ST_ZERO_SIZE;
          end else if (hdr_next.depth != tgad_pkg::DEPTH_24 &&
                       hdr_next.depth != tgad_pkg::DEPTH_32) begin
            hdr_status = tgad_pkg::ST_BAD_DEPTH;
          end else if (hdr_next.img_type != tgad_pkg::TYPE_RAW &&
                       hdr_next.img_type != tgad_pkg::TYPE_RLE) begin
            hdr_status = tgad_pkg::ST_BAD_TYPE;
          end
          if (hdr_status != tgad_pkg::ST_OK) begin
            res_valid  = 1'b1;
            no_trunc   = 1'b1;
            phase_next = tgad_pkg::PH_DONE;
          end else begin
            total_next       = {16'd0, hdr_next.width} * {16'd0, hdr_next.height};
            pixels_done_next = '0;
            pbcount_next     = '0;
            pbytes_next      = '0;
            pkt_repeat_next  = 1'b0;
            pkt_left_next    = '0;
            if (hdr_next.idlen != 8'd0) begin
              idskip_next = hdr_next.idlen;
              phase_next  = tgad_pkg::PH_IDSKIP;
            end else if (hdr_next.img_type == tgad_pkg::TYPE_RLE) begin
              phase_next = tgad_pkg::PH_PACKET;
            end else begin
              phase_next = tgad_pkg::PH_PIXELS;
            end
          end
        end
      end

      tgad_pkg::PH_IDSKIP: begin
        // drop id field bytes
        idskip_next = c_idskip - 8'd1;
        if (idskip_next == 8'd0) begin
          pbcount_next    = '0;
          pbytes_next     = '0;
          pkt_repeat_next = 1'b0;
          pkt_left_next   = '0;
          phase_next      = is_rle ? tgad_pkg::PH_PACKET : tgad_pkg::PH_PIXELS;
        end
      end

      tgad_pkg::PH_PACKET: begin
        // rle packet header
        pkt_left_next   = (b & tgad_pkg::PKT_COUNT_MASK) + 8'd1;
        pkt_repeat_next = b[tgad_pkg::PKT_REPEAT_BIT];
        pbcount_next    = '0;
        pbytes_next     = '0;
        phase_next      = tgad_pkg::PH_PIXELS;
      end

      tgad_pkg::PH_PIXELS: begin
        if (!last_byte) begin
          // gather pixel bytes
          case (c_pbcount)
            2'd0:    pbytes_next[7:0]   = b;
            2'd1:    pbytes_next[15:8]  = b;
            2'd2:    pbytes_next[23:16] = b;
            default: pbytes_next        = c_pbytes;
          endcase
          pbcount_next = c_pbcount + 2'd1;
        end else begin
          pbcount_next = '0;
          pbytes_next  = '0;
          px_b = c_pbytes[7:0];
          px_g = c_pbytes[15:8];
          if (c_hdr.depth == tgad_pkg::DEPTH_32) begin
            px_r = c_pbytes[23:16];
            px_a = b;
          end else begin
            px_r = b;
            px_a = tgad_pkg::ALPHA_OPAQUE;
          end
          // run length, clipped at end of image for repeat packets
          if (is_rle && c_pkt_repeat) begin
            run           = ({24'd0, c_pkt_left} < left) ? c_pkt_left : left[7:0];
            pkt_left_next = '0;
          end else begin
            run = 8'd1;
            if (is_rle) begin
              pkt_left_next = c_pkt_left - 8'd1;
            end
          end
          pixels_done_next = c_done + {24'd0, run};
          res_valid        = 1'b1;
          res.blue         = px_b;
          res.green        = px_g;
          res.red          = px_r;
          res.alpha        = px_a;
          res.first_index  = c_done;
          res.run_length   = run;
          if (pixels_done_next >= c_total) begin
            res.image_done = 1'b1;
            no_trunc       = 1'b1;
            phase_next     = tgad_pkg::PH_DONE;
          end else if (is_rle && pkt_left_next == 8'd0) begin
            phase_next = tgad_pkg::PH_PACKET;
          end
        end
      end

      default: begin
        // idle or finished: bytes are ignored
        no_trunc = 1'b1;
      end
    endcase

    // header-derived fields and status
    res.top_down     = hdr_next.top;
    res.image_width  = hdr_next.width;
    res.image_height = hdr_next.height;
    res.status       = hdr_status;
    if (hdr_status != tgad_pkg::ST_OK) begin
      res.image_done = 1'b1;
    end

    // truncation at file end
    if (byte_in.file_end && !no_trunc) begin
      phase_next     = tgad_pkg::PH_DONE;
      res_valid      = 1'b1;
      res.image_done = 1'b1;
      res.status     = tgad_pkg::ST_TRUNCATED;
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= tgad_pkg::PH_IDLE;
      hcount      <= '0;
      hdr         <= '0;
      idskip      <= '0;
      pixels_done <= '0;
      total       <= '0;
      pkt_left    <= '0;
      pkt_repeat  <= 1'b0;
      pbcount     <= '0;
      pbytes      <= '0;
    end else if (in_fire) begin
      phase       <= phase_next;
      hcount      <= hcount_next;
      hdr         <= hdr_next;
      idskip      <= idskip_next;
      pixels_done <= pixels_done_next;
      total       <= total_next;
      pkt_left    <= pkt_left_next;
      pkt_repeat  <= pkt_repeat_next;
      pbcount     <= pbcount_next;
      pbytes      <= pbytes_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && res_valid) begin
      out_valid <= 1'b1;
    end else if (pix_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      out_reg <= res;
    end
  end

  assign pix_out.valid        = out_valid;
  assign pix_out.blue         = out_reg.blue;
  assign pix_out.green        = out_reg.green;
  assign pix_out.red          = out_reg.red;
  assign pix_out.alpha        = out_reg.alpha;
  assign pix_out.first_index  = out_reg.first_index;
  assign pix_out.run_length   = out_reg.run_length;
  assign pix_out.top_down     = out_reg.top_down;
  assign pix_out.image_width  = out_reg.image_width;
  assign pix_out.image_height = out_reg.image_height;
  assign pix_out.image_done   = out_reg.image_done;
  assign pix_out.status       = out_reg.status;

  // pixel count never reaches the total while pixel data is still expected
  a_done_below_total: assert property (@(posedge clk) disable iff (rst)
    (phase == tgad_pkg::PH_PIXELS || phase == tgad_pkg::PH_PACKET) |->
      (pixels_done < total))
    else $error("pixel count reached total while decoding");

  // a status-only beat always ends the image
  a_empty_run_ends: assert property (@(posedge clk) disable iff (rst)
    (pix_out.valid && pix_out.run_length == 8'd0) |-> pix_out.image_done)
    else $error("empty run without image end");

  // any error status ends the image
  a_error_ends: assert property (@(posedge clk) disable iff (rst)
    (pix_out.valid && pix_out.status != tgad_pkg::ST_OK) |-> pix_out.image_done)
    else $error("error status without image end");

  // runs stay within one rle packet
  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    pix_out.valid |-> (pix_out.run_length <= 8'(tgad_pkg::RUN_MAX)))
    else $error("run longer than one packet");

endmodule

`default_nettype wire

// ----- sim/tga_rle_pixel_decoder_tb.sv -----
// testbench for tga_rle_pixel_decoder: streams tga files byte by byte and checks every run beat
// against a behavioral decoder kept in the bench; depends on tgad_pkg, tgad_if and the decoder
`default_nettype none

module tga_rle_pixel_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [4:0] HDR_BYTES    = 5'd18;
  localparam int         FILE_BYTES   = 600;
  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         SETTLE_CYCLES = 20;

  // one input beat plus its pacing
  typedef struct {
    logic [7:0]  data;
    logic        fs;
    logic        fe;
    int unsigned gap;
    bit          drain;
  } byte_beat_t;

  logic clk;
  logic rst;

  tgad_in_if  byte_if ();
  tgad_out_if run_if ();

  tga_rle_pixel_decoder u_top (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_if),
    .pix_out (run_if)
  );

  byte_beat_t          byte_queue[$];
  logic [7:0]          file_buf[$];
  tgad_pkg::result_t   runs_owed[$];
  bit                  file_calm;
  bit                  file_drain;
  int                  file_bytes_queued;
  int                  fail_count;
  int                  cycle_count;

  // decoder state mirrored in the bench
  tgad_pkg::phase_t    dec_phase;
  logic [4:0]          hdr_cnt;
  tgad_pkg::hdr_t      hdr;
  logic [7:0]          id_left;
  logic [31:0]         px_done;
  logic [31:0]         px_total;
  logic [7:0]          pkt_left;
  logic                pkt_rep;
  logic [1:0]          byte_idx;
  logic [31:0]         px_acc;

  // driver and monitor state
  byte_beat_t          next_beat;
  bit                  armed;
  int unsigned         gap_left;
  int unsigned         hold_left;
  bit                  sink_calm;
  tgad_pkg::result_t   want;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- decoder model

  function automatic void clear_decoder();
    dec_phase = tgad_pkg::PH_IDLE;
    hdr_cnt   = '0;
    hdr       = '0;
    id_left   = '0;
    px_done   = '0;
    px_total  = '0;
    pkt_left  = '0;
    pkt_rep   = 1'b0;
    byte_idx  = '0;
    px_acc    = '0;
  endfunction

  function automatic void start_pixels();
    byte_idx  = '0;
    px_acc    = '0;
    pkt_rep   = 1'b0;
    pkt_left  = '0;
    dec_phase = (hdr.img_type == tgad_pkg::TYPE_RLE) ? tgad_pkg::PH_PACKET
                                                     : tgad_pkg::PH_PIXELS;
  endfunction

  function automatic tgad_pkg::result_t make_run(input logic [31:0] px,
                                                 input logic [31:0] idx,
                                                 input logic [7:0] run, input logic done,
                                                 input tgad_pkg::status_t st);
    tgad_pkg::result_t r;
    r.blue         = px[7:0];
    r.green        = px[15:8];
    r.red          = px[23:16];
    r.alpha        = px[31:24];
    r.first_index  = idx;
    r.run_length   = run;
    r.top_down     = hdr.top;
    r.image_width  = hdr.width;
    r.image_height = hdr.height;
    r.image_done   = done;
    r.status       = st;
    return r;
  endfunction

  // advance the decoder by one accepted byte, queueing the run beat it causes
  task automatic decode_byte(input logic [7:0] b, input logic fs, input logic fe);
    tgad_pkg::result_t r;
    logic              have;
    tgad_pkg::status_t st;
    int                nbytes;
    logic [31:0]       px;
    logic [31:0]       left;
    logic [31:0]       run;
    logic [31:0]       idx;
    have = 1'b0;
    if (fs) begin
      clear_decoder();
      dec_phase = tgad_pkg::PH_HEADER;
    end
    if (dec_phase == tgad_pkg::PH_IDLE || dec_phase == tgad_pkg::PH_DONE) return;

    case (dec_phase)
      tgad_pkg::PH_HEADER: begin
        case (hdr_cnt)
          tgad_pkg::HB_IDLEN:     hdr.idlen = b;
          tgad_pkg::HB_CMAP:      hdr.cmap = (b != 8'd0);
          tgad_pkg::HB_TYPE:      hdr.img_type = b;
          tgad_pkg::HB_WIDTH_LO:  hdr.width[7:0] = b;
          tgad_pkg::HB_WIDTH_HI:  hdr.width[15:8] = b;
          tgad_pkg::HB_HEIGHT_LO: hdr.height[7:0] = b;
          tgad_pkg::HB_HEIGHT_HI: hdr.height[15:8] = b;
          tgad_pkg::HB_DEPTH:     hdr.depth = b;
          tgad_pkg::HB_DESC:      hdr.top = b[tgad_pkg::DESC_TOP_BIT];
          default: ;
        endcase
        hdr_cnt = hdr_cnt + 5'd1;
        if (hdr_cnt == HDR_BYTES) begin
          // header checks in priority order
          if (hdr.cmap) st = tgad_pkg::ST_COLOR_MAP;
          else if (hdr.width == 16'd0 || hdr.height == 16'd0) st = tgad_pkg::ST_ZERO_SIZE;
          else if (hdr.depth != tgad_pkg::DEPTH_24 && hdr.depth != tgad_pkg::DEPTH_32)
            st = tgad_pkg::ST_BAD_DEPTH;
          else if (hdr.img_type != tgad_pkg::TYPE_RAW && hdr.img_type != tgad_pkg::TYPE_RLE)
            st = tgad_pkg::ST_BAD_TYPE;
          else st = tgad_pkg::ST_OK;
          if (st != tgad_pkg::ST_OK) begin
            runs_owed.push_back(make_run(32'd0, 32'd0, 8'd0, 1'b1, st));
            dec_phase = tgad_pkg::PH_DONE;
            return;
          end
          px_total = 32'(hdr.width) * 32'(hdr.height);
          px_done  = '0;
          if (hdr.idlen != 8'd0) begin
            id_left   = hdr.idlen;
            dec_phase = tgad_pkg::PH_IDSKIP;
          end else begin
            start_pixels();
          end
        end
      end
      tgad_pkg::PH_IDSKIP: begin
        id_left = id_left - 8'd1;
        if (id_left == 8'd0) start_pixels();
      end
      tgad_pkg::PH_PACKET: begin
        pkt_left  = (b & tgad_pkg::PKT_COUNT_MASK) + 8'd1;
        pkt_rep   = b[tgad_pkg::PKT_REPEAT_BIT];
        byte_idx  = '0;
        px_acc    = '0;
        dec_phase = tgad_pkg::PH_PIXELS;
      end
      tgad_pkg::PH_PIXELS: begin
        nbytes = (hdr.depth == tgad_pkg::DEPTH_32) ? 4 : 3;
        px_acc = px_acc | (32'(b) << (8 * byte_idx));
        if (int'(byte_idx) + 1 < nbytes) begin
          byte_idx = byte_idx + 2'd1;
        end else begin
          // pixel complete: emit one run
          byte_idx = '0;
          px       = px_acc;
          px_acc   = '0;
          left     = px_total - px_done;
          idx      = px_done;
          if (nbytes == 3) px[31:24] = tgad_pkg::ALPHA_OPAQUE;
          if (hdr.img_type == tgad_pkg::TYPE_RLE && pkt_rep) begin
            run      = (32'(pkt_left) < left) ? 32'(pkt_left) : left;
            pkt_left = '0;
          end else begin
            run = 32'd1;
            if (hdr.img_type == tgad_pkg::TYPE_RLE) pkt_left = pkt_left - 8'd1;
          end
          px_done = px_done + run;
          if (px_done >= px_total) begin
            runs_owed.push_back(make_run(px, idx, run[7:0], 1'b1, tgad_pkg::ST_OK));
            dec_phase = tgad_pkg::PH_DONE;
            return;
          end
          r    = make_run(px, idx, run[7:0], 1'b0, tgad_pkg::ST_OK);
          have = 1'b1;
          if (hdr.img_type == tgad_pkg::TYPE_RLE && pkt_left == 8'd0)
            dec_phase = tgad_pkg::PH_PACKET;
        end
      end
      default: ;
    endcase

    // early end of file
    if (fe) begin
      dec_phase = tgad_pkg::PH_DONE;
      if (have) begin
        r.image_done = 1'b1;
        r.status     = tgad_pkg::ST_TRUNCATED;
      end else begin
        r = make_run(32'd0, 32'd0, 8'd0, 1'b1, tgad_pkg::ST_TRUNCATED);
      end
      runs_owed.push_back(r);
    end else if (have) begin
      runs_owed.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------- file builders

  task automatic put_byte(input logic [7:0] b);
    file_buf.push_back(b);
  endtask

  task automatic put_pixel(input int nbytes);
    repeat (nbytes) put_byte(8'($urandom_range(0, 255)));
  endtask

  // header in stream order; bytes 3..11 are not decoded and stay random
  task automatic put_header(input logic [7:0] idlen, input logic [7:0] cmap_b,
                            input logic [7:0] img_type, input logic [15:0] w,
                            input logic [15:0] h, input logic [7:0] depth,
                            input logic [7:0] desc);
    put_byte(idlen);
    put_byte(cmap_b);
    put_byte(img_type);
    repeat (9) put_byte(8'($urandom_range(0, 255)));
    put_byte(w[7:0]);
    put_byte(w[15:8]);
    put_byte(h[7:0]);
    put_byte(h[15:8]);
    put_byte(depth);
    put_byte(desc);
  endtask

  // rle packets covering total pixels, raw packets capped at max_raw+1 pixels
  task automatic put_packets(input int total, input int nbytes, input int max_raw);
    int remaining;
    int count;
    bit rep;
    remaining = total;
    while (remaining > 0) begin
      rep   = 1'($urandom_range(0, 1));
      count = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 127))
                                          : int'($urandom_range(0, 5));
      if (!rep && count > max_raw) count = max_raw;
      put_byte({rep, 7'(count)});
      if (rep) put_pixel(nbytes);
      else repeat (count + 1) put_pixel(nbytes);
      remaining -= count + 1;
    end
  endtask

  // move the built file onto the byte queue, file_start on its first byte
  task automatic queue_file(input bit fe_last);
    byte_beat_t beat;
    foreach (file_buf[i]) begin
      beat.data  = file_buf[i];
      beat.fs    = (i == 0);
      beat.fe    = fe_last && (i == file_buf.size() - 1);
      beat.gap   = file_calm ? 0 : $urandom_range(0, 5);
      beat.drain = file_drain && (i == 0);
      byte_queue.push_back(beat);
    end
    file_bytes_queued += file_buf.size();
    file_buf.delete();
  endtask

  // bytes with file_start low
  task automatic queue_loose(input int n);
    byte_beat_t beat;
    repeat (n) begin
      beat.data  = 8'($urandom_range(0, 255));
      beat.fs    = 1'b0;
      beat.fe    = 1'($urandom_range(0, 1));
      beat.gap   = $urandom_range(0, 5);
      beat.drain = 1'b0;
      byte_queue.push_back(beat);
    end
  endtask

  // ---------------------------------------------------------------- mismatch reporting

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("[%0t] run beat mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s got %0h exp %0h", name, got, exp_val));
  endtask

  // ---------------------------------------------------------------- byte driver

  always @(posedge clk) begin
    if (rst) begin
      byte_if.valid      <= 1'b0;
      byte_if.data_byte  <= 8'd0;
      byte_if.file_start <= 1'b0;
      byte_if.file_end   <= 1'b0;
      armed = 1'b0;
      gap_left = 0;
      clear_decoder();
    end else begin
      // accepted beat updates the model
      if (byte_if.valid && byte_if.ready)
        decode_byte(byte_if.data_byte, byte_if.file_start, byte_if.file_end);

      // present the next beat once the slot is free
      if (!byte_if.valid || byte_if.ready) begin
        if (byte_queue.size() == 0) begin
          byte_if.valid <= 1'b0;
        end else begin
          if (!armed) begin
            gap_left = byte_queue[0].gap;
            armed = 1'b1;
          end
          if (gap_left != 0) begin
            gap_left--;
            byte_if.valid <= 1'b0;
          end else if (byte_queue[0].drain && runs_owed.size() != 0) begin
            byte_if.valid <= 1'b0;
          end else begin
            next_beat = byte_queue.pop_front();
            armed = 1'b0;
            byte_if.valid      <= 1'b1;
            byte_if.data_byte  <= next_beat.data;
            byte_if.file_start <= next_beat.fs;
            byte_if.file_end   <= next_beat.fe;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- run monitor

  always @(posedge clk) begin
    if (rst) begin
      run_if.ready <= 1'b0;
      hold_left = 0;
      sink_calm = 1'b0;
    end else begin
      if (run_if.valid && run_if.ready) begin
        if (runs_owed.size() == 0) begin
          report_mismatch("run beat with nothing expected");
        end else begin
          want = runs_owed.pop_front();
          check_field("blue", 32'(run_if.blue), 32'(want.blue));
          check_field("green", 32'(run_if.green), 32'(want.green));
          check_field("red", 32'(run_if.red), 32'(want.red));
          check_field("alpha", 32'(run_if.alpha), 32'(want.alpha));
          check_field("first_index", run_if.first_index, want.first_index);
          check_field("run_length", 32'(run_if.run_length), 32'(want.run_length));
          check_field("top_down", 32'(run_if.top_down), 32'(want.top_down));
          check_field("image_width", 32'(run_if.image_width), 32'(want.image_width));
          check_field("image_height", 32'(run_if.image_height), 32'(want.image_height));
          check_field("image_done", 32'(run_if.image_done), 32'(want.image_done));
          check_field("status", 32'(run_if.status), 32'(want.status));
        end
        // occasional switch between stalling and streaming stretches
        if ($urandom_range(0, 31) == 0) sink_calm = !sink_calm;
        hold_left = sink_calm ? 0 : $urandom_range(0, 5);
      end
      if (hold_left != 0) begin
        hold_left--;
        run_if.ready <= 1'b0;
      end else begin
        run_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus and end of run

  initial begin
    int          kind;
    int          err;
    int          w;
    int          h;
    int          idlen;
    int          nbytes;
    int          ending;
    int          cut;
    logic [7:0]  depth;
    logic [7:0]  img_type;
    logic [7:0]  cmap_b;

    rst                = 1'b1;
    byte_if.valid      = 1'b0;
    byte_if.data_byte  = 8'd0;
    byte_if.file_start = 1'b0;
    byte_if.file_end   = 1'b0;
    run_if.ready       = 1'b0;
    fail_count         = 0;
    cycle_count        = 0;
    file_bytes_queued  = 0;
    file_calm          = 1'b0;
    file_drain         = 1'b0;

    // bytes before any file are dropped
    queue_loose(4);

    // raw 24-bit 2x1, rows top first, extreme color bytes
    put_header(8'd0, 8'd0, tgad_pkg::TYPE_RAW, 16'd2, 16'd1, tgad_pkg::DEPTH_24, 8'h20);
    repeat (3) put_byte(8'h00);
    repeat (3) put_byte(8'hFF);
    queue_file(1'b1);

    // rle 32-bit 3x2 with id field: repeat 4, raw 1, repeat 128 clipped to 1, trailing bytes
    file_drain = 1'b1;
    put_header(8'd2, 8'd0, tgad_pkg::TYPE_RLE, 16'd3, 16'd2, tgad_pkg::DEPTH_32, 8'h08);
    put_byte(8'hAA);
    put_byte(8'h55);
    put_byte(8'h83);
    put_pixel(4);
    put_byte(8'h00);
    put_pixel(4);
    put_byte(8'hFF);
    put_pixel(4);
    put_byte(8'h12);
    put_byte(8'h34);
    queue_file(1'b1);
    file_drain = 1'b0;

    // header errors: color map over zero size, zero size, depth, type
    put_header(8'd0, 8'd1, tgad_pkg::TYPE_RAW, 16'd0, 16'd1, tgad_pkg::DEPTH_24, 8'h00);
    queue_file(1'b0);
    put_header(8'd0, 8'd0, tgad_pkg::TYPE_RLE, 16'd4, 16'd0, tgad_pkg::DEPTH_32, 8'h00);
    queue_file(1'b0);
    put_header(8'd0, 8'd0, tgad_pkg::TYPE_RAW, 16'd1, 16'd1, 8'd16, 8'h00);
    queue_file(1'b0);
    put_header(8'd0, 8'd0, 8'd3, 16'd1, 16'd1, tgad_pkg::DEPTH_24, 8'h00);
    put_byte(8'h00);
    queue_file(1'b1);

    // largest image, longest id field, unclipped 128 run, end of file on a completing pixel
    put_header(8'hFF, 8'd0, tgad_pkg::TYPE_RLE, 16'hFFFF, 16'hFFFF, tgad_pkg::DEPTH_32,
               8'hFF);
    repeat (255) put_byte(8'($urandom_range(0, 255)));
    put_byte(8'hFF);
    put_pixel(4);
    put_byte(8'h01);
    put_pixel(4);
    queue_file(1'b1);

    // end of file inside the header
    put_header(8'd0, 8'd0, tgad_pkg::TYPE_RAW, 16'h1234, 16'h5678, tgad_pkg::DEPTH_24,
               8'h00);
    while (file_buf.size() > 15) void'(file_buf.pop_back());
    queue_file(1'b1);

    // end of file on the last header byte of a good header
    put_header(8'd0, 8'd0, tgad_pkg::TYPE_RLE, 16'd2, 16'd2, tgad_pkg::DEPTH_24, 8'h20);
    queue_file(1'b1);

    // start and end of file on one byte
    put_byte(8'h07);
    queue_file(1'b1);

    // end of file inside a pixel
    put_header(8'd0, 8'd0, tgad_pkg::TYPE_RAW, 16'd2, 16'd2, tgad_pkg::DEPTH_32, 8'h00);
    put_pixel(4);
    put_pixel(2);
    queue_file(1'b1);

    // end of file on a packet header byte
    put_header(8'd0, 8'd0, tgad_pkg::TYPE_RLE, 16'd1, 16'd4, tgad_pkg::DEPTH_24, 8'h00);
    put_byte(8'h81);
    put_pixel(3);
    put_byte(8'h02);
    queue_file(1'b1);

    // end of file inside the id field
    put_header(8'd3, 8'd0, tgad_pkg::TYPE_RAW, 16'd1, 16'd1, tgad_pkg::DEPTH_24, 8'h00);
    put_byte(8'h00);
    queue_file(1'b1);

    // restart drops an unfinished image
    put_header(8'd0, 8'd0, tgad_pkg::TYPE_RAW, 16'd2, 16'd2, tgad_pkg::DEPTH_24, 8'h00);
    put_pixel(3);
    put_pixel(2);
    queue_file(1'b0);
    put_header(8'd0, 8'd0, tgad_pkg::TYPE_RAW, 16'd1, 16'd1, tgad_pkg::DEPTH_24, 8'h00);
    put_pixel(3);
    queue_file(1'b0);

    // random files, mostly well formed
    while (file_bytes_queued < FILE_BYTES) begin
      kind       = $urandom_range(0, 99);
      file_calm  = ($urandom_range(0, 3) == 0);
      file_drain = ($urandom_range(0, 7) == 0);
      depth      = $urandom_range(0, 1) ? tgad_pkg::DEPTH_32 : tgad_pkg::DEPTH_24;
      nbytes     = (depth == tgad_pkg::DEPTH_32) ? 4 : 3;
      img_type   = $urandom_range(0, 1) ? tgad_pkg::TYPE_RLE : tgad_pkg::TYPE_RAW;
      idlen      = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 6)) : 0;
      if (kind < 65) begin
        // small image, varied endings
        w = $urandom_range(1, 4);
        h = $urandom_range(1, 4);
        put_header(8'(idlen), 8'd0, img_type, 16'(w), 16'(h), depth,
                   8'($urandom_range(0, 255)));
        repeat (idlen) put_byte(8'($urandom_range(0, 255)));
        if (img_type == tgad_pkg::TYPE_RLE) put_packets(w * h, nbytes, 15);
        else repeat (w * h) put_pixel(nbytes);
        ending = $urandom_range(0, 9);
        if (ending == 6) repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)));
        if (ending == 7 || ending == 8) begin
          cut = int'($urandom_range(1, file_buf.size() - 1));
          while (file_buf.size() > cut) void'(file_buf.pop_back());
        end
        queue_file(ending <= 7);
      end else if (kind < 75) begin
        // large image cut short
        w = $urandom_range(512, 65535);
        h = $urandom_range(512, 65535);
        if ($urandom_range(0, 3) != 0) img_type = tgad_pkg::TYPE_RLE;
        put_header(8'(idlen), 8'd0, img_type, 16'(w), 16'(h), depth,
                   8'($urandom_range(0, 255)));
        repeat (idlen) put_byte(8'($urandom_range(0, 255)));
        if (img_type == tgad_pkg::TYPE_RLE) put_packets($urandom_range(1, 300), nbytes, 127);
        else repeat ($urandom_range(1, 6)) put_pixel(nbytes);
        while (file_buf.size() > int'(HDR_BYTES) + idlen + 40) void'(file_buf.pop_back());
        queue_file(1'b1);
      end else if (kind < 90) begin
        // broken header
        err    = $urandom_range(0, 4);
        cmap_b = (err == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
        w      = $urandom_range(1, 3);
        h      = $urandom_range(1, 3);
        if (err == 1) begin
          if ($urandom_range(0, 1)) w = 0;
          else h = 0;
        end
        if (err == 2) depth = 8'($urandom_range(0, 255));
        if (err == 3) img_type = 8'($urandom_range(0, 255));
        if (err == 4) begin
          cmap_b   = 8'($urandom_range(0, 255));
          w        = $urandom_range(0, 65535);
          h        = $urandom_range(0, 65535);
          depth    = 8'($urandom_range(0, 255));
          img_type = 8'($urandom_range(0, 255));
        end
        put_header(8'($urandom_range(0, 3)), cmap_b, img_type, 16'(w), 16'(h), depth,
                   8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 4)) put_byte(8'($urandom_range(0, 255)));
        queue_file(1'($urandom_range(0, 1)));
      end else begin
        queue_loose($urandom_range(1, 6));
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (byte_queue.size() != 0 || byte_if.valid || runs_owed.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
